// ----- rtl/core/ddstwsl_pkg.sv -----
// ============================================================================
// ddstwsl_pkg
// Shared widths, pulse codes, register indexes and the controller/datapath
// command and status types of the DDS tuning-word serial loader.
// ============================================================================
package ddstwsl_pkg;

   // Default parameter values
   localparam int SCALE_FRAC_BITS_DEF = 24;
   localparam int FREQ_BITS_DEF       = 25;

   // Fixed field widths
   localparam int SCALE_W = 32;
   localparam int WORD_W  = 32;
   localparam int CTRL_W  = 8;
   localparam int KIND_W  = 2;
   localparam int SREG_W  = WORD_W + CTRL_W;
   localparam int CNT_W   = $clog2(SREG_W);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_TUNING_SCALE = 1'b0;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd2401996663;

   // Input operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_RESET = 1'b1;

   // Pulse kinds
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WCLK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FQUD  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic              capture;    // latch request and form the product
      logic              load_sreg;  // load saturated word and control byte
      logic              emit;       // write a pulse into the output register
      logic [KIND_W-1:0] kind;
      logic              use_sreg;   // send the next shift-register bit
      logic              last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;  // output register empty or being taken this cycle
      logic req_op;    // operation of the request currently offered
   } sts_type;

endpackage

// ----- rtl/core/ddstwsl_if.sv -----
// ============================================================================
// ddstwsl_req_if / ddstwsl_rsp_if
// Valid/ready channel interfaces for request items and pulse results.
// ============================================================================
interface ddstwsl_req_if #(
   parameter int FREQ_BITS = ddstwsl_pkg::FREQ_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [FREQ_BITS-1:0]         frequency_hz;
   logic [ddstwsl_pkg::CTRL_W-1:0] control_byte;

   modport source (output valid, output op, output frequency_hz,
                   output control_byte, input ready);
   modport sink   (input valid, input op, input frequency_hz,
                   input control_byte, output ready);
endinterface

interface ddstwsl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ddstwsl_pkg::KIND_W-1:0] pulse_kind;
   logic                           data_bit;
   logic                           last;

   modport source (output valid, output pulse_kind, output data_bit,
                   output last, input ready);
   modport sink   (input valid, input pulse_kind, input data_bit,
                   input last, output ready);
endinterface

// ----- rtl/core/ddstwsl_ctrl.sv -----
// ============================================================================
// ddstwsl_ctrl
// Sequencer: steps through the pulses of a load or reset transaction.
// ============================================================================
module ddstwsl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ddstwsl_pkg::sts_type sts,
   output ddstwsl_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SHIFT = 3'd2;
   localparam logic [2:0] ST_FQUD  = 3'd3;
   localparam logic [2:0] ST_RPIN  = 3'd4;
   localparam logic [2:0] ST_RCLK  = 3'd5;
   localparam logic [2:0] ST_RFQUD = 3'd6;

   localparam logic [ddstwsl_pkg::CNT_W-1:0] CNT_LAST =
      ddstwsl_pkg::CNT_W'(ddstwsl_pkg::SREG_W - 1);

   logic [2:0]                      state_ff, state_in;
   logic [ddstwsl_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.kind      = ddstwsl_pkg::KIND_WCLK;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (sts.req_op == ddstwsl_pkg::OP_RESET) ? ST_RPIN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_sreg = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.use_sreg = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_in = ST_FQUD;
               end
            end
         end
         ST_FQUD, ST_RFQUD: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = ddstwsl_pkg::KIND_FQUD;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RPIN: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = ddstwsl_pkg::KIND_RESET;
               state_in = ST_RCLK;
            end
         end
         ST_RCLK: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_RFQUD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/ddstwsl_dp.sv -----
// ============================================================================
// ddstwsl_dp
// Datapath: product register, saturation, 40-bit shift register, data-line
// level and the output register of the pulse channel.
// ============================================================================
module ddstwsl_dp #(
   parameter int SCALE_FRAC_BITS = ddstwsl_pkg::SCALE_FRAC_BITS_DEF,
   parameter int FREQ_BITS       = ddstwsl_pkg::FREQ_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ddstwsl_pkg::cmd_type                cmd,
   output ddstwsl_pkg::sts_type                sts,
   input  logic                                req_op,
   input  logic [FREQ_BITS-1:0]                req_frequency_hz,
   input  logic [ddstwsl_pkg::CTRL_W-1:0]      req_control_byte,
   input  logic [ddstwsl_pkg::SCALE_W-1:0]     tuning_scale,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ddstwsl_pkg::KIND_W-1:0]      rsp_pulse_kind,
   output logic                                rsp_data_bit,
   output logic                                rsp_last
);

   localparam int PROD_W = FREQ_BITS + ddstwsl_pkg::SCALE_W;
   localparam int WORD_W = ddstwsl_pkg::WORD_W;

   logic [PROD_W-1:0]                   prod_ff, prod_in;
   logic [ddstwsl_pkg::CTRL_W-1:0]      ctrl_ff, ctrl_in;
   logic [ddstwsl_pkg::SREG_W-1:0]      sreg_ff, sreg_in;
   logic                                level_ff, level_in;
   logic                                valid_ff, valid_in;
   logic [ddstwsl_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic                                bit_ff, bit_in;
   logic                                last_ff, last_in;
   logic [PROD_W-1:0]                   shifted;
   logic [WORD_W-1:0]                   word;
   logic                                send_bit;

   // Drop the fraction, then clamp anything above 32 bits to all ones.
   assign shifted = prod_ff >> SCALE_FRAC_BITS;
   assign word    = (|shifted[PROD_W-1:WORD_W]) ? '1 : shifted[WORD_W-1:0];

   assign send_bit = cmd.use_sreg ? sreg_ff[0] : level_ff;

   assign sts.out_free = !valid_ff || rsp_ready;
   assign sts.req_op   = req_op;

   always_comb begin
      prod_in  = prod_ff;
      ctrl_in  = ctrl_ff;
      sreg_in  = sreg_ff;
      level_in = level_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      bit_in   = bit_ff;
      last_in  = last_ff;
      if (cmd.capture) begin
         prod_in = PROD_W'(req_frequency_hz) * PROD_W'(tuning_scale);
         ctrl_in = req_control_byte;
      end
      if (cmd.load_sreg) begin
         sreg_in = {ctrl_ff, word};
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.kind;
         bit_in   = send_bit;
         last_in  = cmd.last;
         if (cmd.use_sreg) begin
            sreg_in  = sreg_ff >> 1;
            level_in = sreg_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         level_ff <= level_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ctrl_ff <= ctrl_in;
      sreg_ff <= sreg_in;
      kind_ff <= kind_in;
      bit_ff  <= bit_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pulse_kind = kind_ff;
   assign rsp_data_bit   = bit_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- rtl/core/dds_tuning_word_serial_loader_core.sv -----
// ============================================================================
// dds_tuning_word_serial_loader_core
// Turns frequency requests into the pulse sequence of a 40-bit serial DDS
// tuning-word load, or into the chip's reset sequence.
// ============================================================================
// Usage. A request transaction on req carries an operation, a frequency in
// hertz and a control byte. Each pulse for the DDS pins leaves as one
// transaction on rsp: the pin kind, the data-line level held during the
// pulse, and a flag on the final pulse of the request.
// A load multiplies the frequency by the tuning_scale register (unsigned,
// SCALE_FRAC_BITS fractional bits), truncates and saturates to 32 bits, and
// sends 40 word-clock pulses (tuning word, then control byte, both LSB
// first) followed by one frequency-update pulse: 41 pulses in all.
// A reset request sends reset pin, word clock and frequency update, each
// with the data line at its previous level.
// A load presents its first pulse after the product register and then the
// shift-register load, and then at most one pulse per cycle. req is ready
// again as soon as the final pulse is in the output register, so the next
// request overlaps with its delivery. The multiplier and the one-bit-a-cycle
// shift register set this pace.
// When the receiver stalls, the output register holds its pulse and the
// sequencer waits; no pulse is dropped. Reset empties the output register,
// returns the sequencer to idle, clears the data-line level and restores
// tuning_scale to its default. The user must write tuning_scale over the APB
// port only while no request is in progress; the block does not enforce it.
// ============================================================================
module dds_tuning_word_serial_loader_core #(
   parameter int SCALE_FRAC_BITS = ddstwsl_pkg::SCALE_FRAC_BITS_DEF,
   parameter int FREQ_BITS       = ddstwsl_pkg::FREQ_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ddstwsl_req_if.sink                          req,
   ddstwsl_rsp_if.source                        rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ddstwsl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ddstwsl_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ddstwsl_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                 pready
);

   ddstwsl_pkg::cmd_type               cmd;
   ddstwsl_pkg::sts_type               sts;
   logic [ddstwsl_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic                               reg_index;
   logic                               reg_write;

   // Registers sit on 4-byte boundaries, so the word index starts at bit 2.
   // Anything beyond the single register reads as zero and ignores writes.
   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      scale_in = scale_ff;
      if (reg_write && (reg_index == ddstwsl_pkg::REG_TUNING_SCALE)) begin
         scale_in = pwdata;
      end
   end

   assign prdata = (reg_index == ddstwsl_pkg::REG_TUNING_SCALE) ? scale_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ddstwsl_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // The sequencer decides which pulse goes out next; the datapath holds
   // the numbers and the output register.
   ddstwsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ddstwsl_dp #(
      .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
      .FREQ_BITS       (FREQ_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req.op),
      .req_frequency_hz (req.frequency_hz),
      .req_control_byte (req.control_byte),
      .tuning_scale     (scale_ff),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_pulse_kind   (rsp.pulse_kind),
      .rsp_data_bit     (rsp.data_bit),
      .rsp_last         (rsp.last)
   );

endmodule

// ----- rtl/core/ddstwsl_checker.sv -----
// ============================================================================
// ddstwsl_checker
// Port-level checks of the serial loader, bound to the top level.
// ============================================================================
module ddstwsl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ddstwsl_pkg::KIND_W-1:0] rsp_pulse_kind,
   input logic                           rsp_data_bit,
   input logic                           rsp_last
);

   // A stalled pulse keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_kind)
         && $stable(rsp_data_bit) && $stable(rsp_last))
      else $error("pulse changed while stalled");

   // Only one request is in progress at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // Every request ends on a frequency-update pulse.
   a_last_is_fqud: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_pulse_kind == ddstwsl_pkg::KIND_FQUD)
      else $error("final pulse is not a frequency update");

   // The reset pin and the word clock never end a request.
   a_fqud_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pulse_kind == ddstwsl_pkg::KIND_RESET
         || rsp_pulse_kind == ddstwsl_pkg::KIND_WCLK) |-> !rsp_last)
      else $error("request ended on a pulse other than frequency update");

   // A reset-pin pulse that is taken is not directly followed by another reset-pin pulse.
   a_reset_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_pulse_kind == ddstwsl_pkg::KIND_RESET
         |=> !(rsp_valid && rsp_pulse_kind == ddstwsl_pkg::KIND_RESET))
      else $error("reset pin pulsed twice in a row");

endmodule

bind dds_tuning_word_serial_loader_core ddstwsl_checker u_ddstwsl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_pulse_kind (rsp.pulse_kind),
   .rsp_data_bit   (rsp.data_bit),
   .rsp_last       (rsp.last)
);

// ----- tb/sv/tb_dds_tuning_word_serial_loader_core.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_dds_tuning_word_serial_loader_core
// Self-checking bench for the DDS tuning-word serial loader. Load and reset
// transactions go in on req, and every pin pulse that comes back on rsp is
// checked against a pulse sequence predicted inside the bench. The
// tuning_scale register is set to several values, extremes included,
// between phases with different amounts of idling on both channels.
// ============================================================================
module tb_dds_tuning_word_serial_loader_core;

   localparam int FREQ_W          = ddstwsl_pkg::FREQ_BITS_DEF;
   localparam int SCALE_W         = ddstwsl_pkg::SCALE_W;
   localparam int WORD_W          = ddstwsl_pkg::WORD_W;
   localparam int CTRL_W          = ddstwsl_pkg::CTRL_W;
   localparam int KIND_W          = ddstwsl_pkg::KIND_W;
   localparam int SREG_W          = ddstwsl_pkg::SREG_W;
   localparam int CSR_ADDR_W      = ddstwsl_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W      = ddstwsl_pkg::CSR_DATA_W;
   localparam int FRAC_BITS       = ddstwsl_pkg::SCALE_FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles without any transaction
   localparam int DRAIN_CYCLES    = 48;    // a little over one load
   localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall for back-pressure

   // Byte addresses on the register port: register i sits at 4*i. The second
   // address lies beyond the register list, so writes to it must be ignored.
   localparam logic [CSR_ADDR_W-1:0] SCALE_ADDR    =
      CSR_ADDR_W'(4 * ddstwsl_pkg::REG_TUNING_SCALE);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = CSR_ADDR_W'(4);

   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

   // One pin pulse as it appears on the result channel.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              data;
      logic              last;
   } pulse_type;

   // -------------------------------------------------------------------------
   // Pulse scoreboard. It keeps its own copy of tuning_scale and of the serial
   // data-line level, expands every accepted request into the pulses that it
   // must cause, and checks the pulses that leave the block in order.
   // -------------------------------------------------------------------------
   class pulse_scoreboard;
      logic [SCALE_W-1:0] scale;
      logic               line_level;
      pulse_type          expected_pulses[$];
      int                 errors;

      function new();
         scale      = ddstwsl_pkg::SCALE_RESET;
         line_level = 1'b0;
         errors     = 0;
      endfunction

      // Frequency times scale, with the fractional bits dropped, clamped to
      // all ones when the result needs more than 32 bits.
      function logic [WORD_W-1:0] tuning_word(input logic [FREQ_W-1:0] freq);
         logic [63:0] product;
         product = (64'(freq) * 64'(scale)) >> FRAC_BITS;
         if (product > 64'hFFFF_FFFF)
            return '1;
         return product[WORD_W-1:0];
      endfunction

      function void push_pulse(input logic [KIND_W-1:0] kind, input logic last);
         pulse_type p;
         p.kind = kind;
         p.data = line_level;
         p.last = last;
         expected_pulses.push_back(p);
      endfunction

      function void note_request(input logic op, input logic [FREQ_W-1:0] freq,
                                 input logic [CTRL_W-1:0] ctrl);
         logic [SREG_W-1:0] frame;
         if (op == ddstwsl_pkg::OP_RESET) begin
            // The data line is left where the previous load put it.
            push_pulse(ddstwsl_pkg::KIND_RESET, 1'b0);
            push_pulse(ddstwsl_pkg::KIND_WCLK, 1'b0);
            push_pulse(ddstwsl_pkg::KIND_FQUD, 1'b1);
         end else begin
            // Tuning word first, then the control byte, both LSB first.
            frame = {ctrl, tuning_word(freq)};
            for (int i = 0; i < SREG_W; i++) begin
               line_level = frame[i];
               push_pulse(ddstwsl_pkg::KIND_WCLK, 1'b0);
            end
            push_pulse(ddstwsl_pkg::KIND_FQUD, 1'b1);
         end
      endfunction

      function void check_pulse(input pulse_type actual);
         pulse_type wanted;
         if (expected_pulses.size() == 0) begin
            errors++;
            $display("%0t: unexpected pulse: expected none, got kind %0d data %0d last %0d",
                     $time, actual.kind, actual.data, actual.last);
            return;
         end
         wanted = expected_pulses.pop_front();
         if (actual.kind !== wanted.kind || actual.data !== wanted.data ||
             actual.last !== wanted.last) begin
            errors++;
            $display("%0t: pulse mismatch: expected kind %0d data %0d last %0d,",
                     $time, wanted.kind, wanted.data, wanted.last,
                     " got kind %0d data %0d last %0d",
                     actual.kind, actual.data, actual.last);
         end
      endfunction

      function int pending();
         return expected_pulses.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block itself.
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ddstwsl_req_if #(.FREQ_BITS(FREQ_W)) req_bus ();
   ddstwsl_rsp_if                       rsp_bus ();

   dds_tuning_word_serial_loader_core #(
      .SCALE_FRAC_BITS (FRAC_BITS),
      .FREQ_BITS       (FREQ_W)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   pulse_scoreboard sb;

   // Idling percentages, written only by the stimulus process. The hold-off
   // request counter is also written there; the receiver keeps its own count
   // of the hold-offs it has served, so each variable has a single writer.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int quiet_cycles      = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, while the inputs are
   // only changed at the falling edge, so the order of events cannot matter.
   // A request is noted before a pulse is checked; a request's first pulse
   // only reaches the output register after its acceptance, so both orders would agree.
   // The watchdog counts cycles in which neither channel completes a
   // transaction and stops the run when the count reaches its limit.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.op, req_bus.frequency_hz, req_bus.control_byte);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_pulse('{rsp_bus.pulse_kind, rsp_bus.data_bit, rsp_bus.last});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d pulses outstanding",
                     $time, sb.pending());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. Ready is redrawn at every falling edge according to the stall
   // percentage of the phase. When a hold-off is requested, ready stays low
   // for a long stretch so that the block fills up and stalls its input while
   // the sender keeps offering transactions.
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_served != hold_off_requests) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_served++;
         end
         rsp_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Register port tasks. A write takes a setup and an access cycle; pready is
   // waited for even though the block keeps it high.
   // -------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = addr;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      if (addr == SCALE_ADDR)
         sb.scale = value;
   endtask

   // Reads tuning_scale back and compares it with the bench's own copy.
   task automatic csr_check_scale();
      logic [CSR_DATA_W-1:0] readback;
      psel    = 1'b1;
      pwrite  = 1'b0;
      penable = 1'b0;
      paddr   = SCALE_ADDR;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (readback !== sb.scale) begin
         sb.errors++;
         $display("%0t: tuning_scale readback mismatch: expected %08h, got %08h",
                  $time, sb.scale, readback);
      end
   endtask

   // -------------------------------------------------------------------------
   // Request tasks. valid stays high from one transaction to the next unless
   // an idle gap is drawn, so it is never dropped and raised in one step.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic op, input logic [FREQ_W-1:0] freq,
                               input logic [CTRL_W-1:0] ctrl);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.op           = op;
      req_bus.frequency_hz = freq;
      req_bus.control_byte = ctrl;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Mostly loads; frequencies lean towards the ends of the range so that
   // both zero words and saturated words turn up wherever the scale allows them.
   task automatic send_random_request();
      logic [FREQ_W-1:0] freq;
      int                pick;
      pick = $urandom_range(7);
      case (pick)
         0: begin
            freq = '0;
         end
         1: begin
            freq = FREQ_MAX;
         end
         2, 3: begin
            freq = FREQ_W'($urandom_range(65535));
         end
         default: begin
            freq = FREQ_W'($urandom);
         end
      endcase
      send_request(($urandom_range(4) == 0) ? ddstwsl_pkg::OP_RESET : ddstwsl_pkg::OP_LOAD,
                   freq, CTRL_W'($urandom));
   endtask

   // Lets every predicted pulse arrive, then waits out one more load time.
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One phase: set the scale while the block is idle, confirm it by reading
   // it back, then run random traffic under the given idling.
   task automatic run_phase(input logic [SCALE_W-1:0] scale_value, input int sender_pct,
                            input int receiver_pct, input int count, input bit hold_off);
      wait_drained();
      csr_write(SCALE_ADDR, scale_value);
      csr_check_scale();
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
      if (hold_off)
         hold_off_requests++;
      repeat (count) send_random_request();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      sb                   = new();
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = ddstwsl_pkg::OP_LOAD;
      req_bus.frequency_hz = '0;
      req_bus.control_byte = '0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The register must come out of reset at its default value.
      csr_check_scale();

      // Directed part, default scale, no idling. A reset sequence straight
      // after reset must carry a low data line; after a load it must carry
      // bit 7 of that load's control byte.
      send_request(ddstwsl_pkg::OP_RESET, '0, '0);
      send_request(ddstwsl_pkg::OP_LOAD, '0, 8'h00);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_MAX, 8'hFF);     // saturated word
      send_request(ddstwsl_pkg::OP_RESET, FREQ_MAX, 8'hFF);    // data line left high
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(1), 8'h80);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_MAX, 8'h7F);
      send_request(ddstwsl_pkg::OP_RESET, '0, '0);             // data line left low
      // Just below and just above the point where the word saturates at the
      // default scale: the first gives a word a few counts short of all ones.
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(29999040), 8'h01);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(29999041), 8'h01);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(30000000), 8'hAA);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(12345678), 8'h55);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(25'h0AAAAAA), 8'h5A);
      send_request(ddstwsl_pkg::OP_RESET, '0, '0);
      send_request(ddstwsl_pkg::OP_RESET, '0, '0);             // two reset sequences in a row
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(25'h1555555), 8'hA5);
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(1000000), 8'hC3);

      // A write beyond the register list must leave tuning_scale untouched.
      wait_drained();
      csr_write(UNMAPPED_ADDR, $urandom);
      csr_check_scale();
      send_request(ddstwsl_pkg::OP_LOAD, FREQ_W'(1000000), 8'h3C);

      // Random phases across the scale extremes and the idling patterns.
      run_phase('0,                        0,  0, 30, 1'b0);
      run_phase('1,                       83,  0, 40, 1'b0);
      run_phase(SCALE_W'(1) << FRAC_BITS,  0, 83, 40, 1'b0);
      run_phase($urandom,                  6,  6, 60, 1'b0);
      run_phase(ddstwsl_pkg::SCALE_RESET,  0,  0, 60, 1'b1);
      run_phase($urandom,                  0, 83, 40, 1'b0);
      run_phase($urandom,                 83,  0, 40, 1'b0);
      run_phase($urandom,                  6,  6, 40, 1'b0);

      // Stray pulses after the last expected one are still caught here.
      wait_drained();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
